// ===== design/block_int8_requantize_tile_unit_macros.svh =====
// Assertion helpers for the top-level design file.
`ifndef BLOCK_INT8_REQUANTIZE_TILE_UNIT_MACROS_SVH
`define BLOCK_INT8_REQUANTIZE_TILE_UNIT_MACROS_SVH

// Same-cycle implication on clk, held off during reset.
`define BRQ_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication on clk, held off during reset.
`define BRQ_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/brq_pkg.sv =====
// ============================================================================
// brq_pkg
// Types and constants of the int8 requantize / tile index pipeline.
// ============================================================================
package brq_pkg;

    localparam int MAX_K    = 4096;
    localparam int K_W      = 13;
    localparam int IDX_W    = 24;
    localparam int CFG_W    = 32;
    localparam int M1_W     = 19;
    localparam int MF_W     = 24;
    localparam int PROD_W   = 43;
    localparam int EXP_W    = 10;
    localparam int MANT_W   = 25;

    // configuration register indexes
    localparam logic CFG_K_SIZE = 1'b0;
    localparam logic CFG_SCALE  = 1'b1;

    typedef struct packed {
        logic [11:0]       weight_row;
        logic [11:0]       weight_col;
        logic [15:0]       block_scale;
        logic signed [7:0] quant_value;
    } brq_in_t;

    typedef struct packed {
        logic [IDX_W-1:0]  dest_index;
        logic signed [7:0] dest_value;
    } brq_out_t;

    typedef struct packed {
        logic [K_W-1:0]   k_size;
        logic [CFG_W-1:0] gain_bits;
    } brq_cfg_t;

    typedef struct packed {
        logic is_nan;
        logic is_inf;
        logic neg;
    } brq_flags_t;

    typedef struct packed {
        logic [IDX_W-1:0]        idx;
        brq_flags_t              flags;
        logic [M1_W-1:0]         m1;
        logic [MF_W-1:0]         mf;
        logic signed [EXP_W-1:0] exp_s;
    } brq_s1_t;

    typedef struct packed {
        logic [IDX_W-1:0]        idx;
        brq_flags_t              flags;
        logic [PROD_W-1:0]       prod;
        logic signed [EXP_W-1:0] exp_s;
    } brq_s2_t;

    typedef struct packed {
        logic [IDX_W-1:0]        idx;
        brq_flags_t              flags;
        logic                    is_zero;
        logic [PROD_W-1:0]       norm;
        logic signed [EXP_W-1:0] exp_e;
    } brq_s3_t;

    typedef struct packed {
        logic [IDX_W-1:0]        idx;
        brq_flags_t              flags;
        logic                    is_zero;
        logic [MANT_W-1:0]       mant;
        logic signed [EXP_W-1:0] exp_e;
    } brq_s4_t;

endpackage

// ===== design/brq_decode.sv =====
// ============================================================================
// brq_decode
// Stage 1: float decode, |q| x half mantissa, special cases, tile index.
// ============================================================================
module brq_decode (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              in_valid,
    input  brq_pkg::brq_in_t  in_data,
    input  brq_pkg::brq_cfg_t cfg,
    output logic              valid_reg,
    output brq_pkg::brq_s1_t  data_reg
);
    import brq_pkg::*;

    logic [4:0]              hex;
    logic [9:0]              hman;
    logic [7:0]              fex;
    logic [22:0]             fman;
    logic [10:0]             mh;
    logic [7:0]              aq;
    logic signed [EXP_W-1:0] eh;
    logic signed [EXP_W-1:0] ef;
    logic                    d_inf, d_nan, d_zero, f_inf, f_nan, f_zero, q_zero;
    logic                    v_nan, v_inf, v_zero;
    logic [K_W-1:0]          k_sat;
    logic [14:0]             tile_prod;
    logic [IDX_W:0]          idx_full;
    brq_s1_t                 data_next;

    always_comb
    begin
        hex  = in_data.block_scale[14:10];
        hman = in_data.block_scale[9:0];
        fex  = cfg.gain_bits[30:23];
        fman = cfg.gain_bits[22:0];

        mh = (hex == 5'd0) ? {1'b0, hman} : {1'b1, hman};
        eh = (hex == 5'd0) ? -10'sd24 : ($signed({5'b0, hex}) - 10'sd25);
        data_next.mf    = (fex == 8'd0) ? {1'b0, fman} : {1'b1, fman};
        ef = (fex == 8'd0) ? -10'sd149 : ($signed({2'b0, fex}) - 10'sd150);
        aq = in_data.quant_value[7] ? (~in_data.quant_value + 8'd1) : in_data.quant_value;

        d_inf  = (hex == 5'h1F) && (hman == 10'd0);
        d_nan  = (hex == 5'h1F) && (hman != 10'd0);
        d_zero = (hex == 5'd0) && (hman == 10'd0);
        f_inf  = (fex == 8'hFF) && (fman == 23'd0);
        f_nan  = (fex == 8'hFF) && (fman != 23'd0);
        f_zero = (fex == 8'd0) && (fman == 23'd0);
        q_zero = (in_data.quant_value == 8'sd0);

        v_nan  = d_nan || (d_inf && q_zero);
        v_inf  = d_inf && !q_zero;
        v_zero = !d_inf && !d_nan && (q_zero || d_zero);

        data_next.flags.is_nan = v_nan || f_nan || (v_inf && f_zero) || (f_inf && v_zero);
        data_next.flags.is_inf = !data_next.flags.is_nan && (v_inf || f_inf);
        data_next.flags.neg    = in_data.quant_value[7] ^ in_data.block_scale[15]
                                 ^ cfg.gain_bits[31];

        // q * half is exact in single precision: 8 x 11 bit significand
        data_next.m1    = M1_W'(aq) * M1_W'(mh);
        data_next.exp_s = eh + ef;

        k_sat     = (cfg.k_size > K_W'(MAX_K)) ? K_W'(MAX_K) : cfg.k_size;
        tile_prod = 15'(in_data.weight_row[11:5]) * 15'(k_sat[12:5]);
        idx_full  = {tile_prod, 10'd0}
                  + (IDX_W+1)'({in_data.weight_col[11:5], 10'd0})
                  + (IDX_W+1)'({in_data.weight_row[4:0], 5'd0})
                  + (IDX_W+1)'(in_data.weight_col[4:0]);
        data_next.idx = idx_full[IDX_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            data_reg <= data_next;
        end
    end

endmodule

// ===== design/brq_mul.sv =====
// ============================================================================
// brq_mul
// Stage 2: exact product of value significand and scale factor significand.
// ============================================================================
module brq_mul (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             en,
    input  logic             in_valid,
    input  brq_pkg::brq_s1_t in_data,
    output logic             valid_reg,
    output brq_pkg::brq_s2_t data_reg
);
    import brq_pkg::*;

    brq_s2_t data_next;

    always_comb
    begin
        data_next.idx   = in_data.idx;
        data_next.flags = in_data.flags;
        data_next.exp_s = in_data.exp_s;
        data_next.prod  = PROD_W'(in_data.m1) * PROD_W'(in_data.mf);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            data_reg <= data_next;
        end
    end

endmodule

// ===== design/brq_norm.sv =====
// ============================================================================
// brq_norm
// Stage 3: leading-zero count and normalizing shift, six binary steps.
// ============================================================================
module brq_norm (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             en,
    input  logic             in_valid,
    input  brq_pkg::brq_s2_t in_data,
    output logic             valid_reg,
    output brq_pkg::brq_s3_t data_reg
);
    import brq_pkg::*;

    logic [63:0] t0, t1, t2, t3, t4, t5, t6;
    logic [5:0]  sh;
    brq_s3_t     data_next;

    always_comb
    begin
        t0 = {in_data.prod, 21'd0};
        sh = 6'd0;
        t1 = t0;
        if (t0[63:32] == 32'd0)
        begin
            t1 = {t0[31:0], 32'd0};
            sh[5] = 1'b1;
        end
        t2 = t1;
        if (t1[63:48] == 16'd0)
        begin
            t2 = {t1[47:0], 16'd0};
            sh[4] = 1'b1;
        end
        t3 = t2;
        if (t2[63:56] == 8'd0)
        begin
            t3 = {t2[55:0], 8'd0};
            sh[3] = 1'b1;
        end
        t4 = t3;
        if (t3[63:60] == 4'd0)
        begin
            t4 = {t3[59:0], 4'd0};
            sh[2] = 1'b1;
        end
        t5 = t4;
        if (t4[63:62] == 2'd0)
        begin
            t5 = {t4[61:0], 2'd0};
            sh[1] = 1'b1;
        end
        t6 = t5;
        if (t5[63] == 1'b0)
        begin
            t6 = {t5[62:0], 1'b0};
            sh[0] = 1'b1;
        end

        data_next.idx     = in_data.idx;
        data_next.flags   = in_data.flags;
        data_next.is_zero = (in_data.prod == '0);
        data_next.norm    = t6[63:21];
        // exponent of the leading bit
        data_next.exp_e   = in_data.exp_s + 10'sd42 - $signed({4'd0, sh});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            data_reg <= data_next;
        end
    end

endmodule

// ===== design/brq_round.sv =====
// ============================================================================
// brq_round
// Stage 4: round to single (nearest even). Stage 5: clamp, round half away
// from zero, special values; this stage is the output register.
// ============================================================================
module brq_round (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en_rnd,
    input  logic              en_out,
    input  logic              in_valid,
    input  brq_pkg::brq_s3_t  in_data,
    output logic              rnd_valid_reg,
    output logic              out_valid_reg,
    output brq_pkg::brq_out_t out_reg
);
    import brq_pkg::*;

    brq_s4_t     rnd_reg;
    brq_s4_t     rnd_next;
    brq_out_t    out_next;
    logic        inc;
    logic [3:0]  sa;
    logic [33:0] fixed_val;
    logic [33:0] sum;
    logic [7:0]  ipart;
    logic [6:0]  mag;

    always_comb
    begin
        inc = in_data.norm[18] && ((|in_data.norm[17:0]) || in_data.norm[19]);
        rnd_next.idx     = in_data.idx;
        rnd_next.flags   = in_data.flags;
        rnd_next.is_zero = in_data.is_zero;
        rnd_next.exp_e   = in_data.exp_e;
        rnd_next.mant    = {1'b0, in_data.norm[42:19]} + MANT_W'(inc);
    end

    always_comb
    begin
        // value = mant * 2^(exp_e-23); fixed point with 26 fraction bits
        sa        = 4'(rnd_reg.exp_e + 10'sd3);
        fixed_val = 34'(rnd_reg.mant) << sa;
        sum       = fixed_val + (34'd1 << 25);
        ipart     = sum[33:26];
        priority if (rnd_reg.is_zero || rnd_reg.exp_e < -10'sd2)
            mag = 7'd0;
        else if (rnd_reg.exp_e > 10'sd6 || ipart > 8'd127)
            mag = 7'd127;
        else
            mag = ipart[6:0];

        out_next.dest_index = rnd_reg.idx;
        priority if (rnd_reg.flags.is_nan)
            out_next.dest_value = -8'sd127;
        else if (rnd_reg.flags.is_inf)
            out_next.dest_value = rnd_reg.flags.neg ? -8'sd127 : 8'sd127;
        else
            out_next.dest_value = rnd_reg.flags.neg ? $signed(8'd0 - {1'b0, mag})
                                                    : $signed({1'b0, mag});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rnd_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (en_rnd)
            begin
                rnd_valid_reg <= in_valid;
            end
            if (en_out)
            begin
                out_valid_reg <= rnd_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en_rnd)
        begin
            rnd_reg <= rnd_next;
        end
        if (en_out)
        begin
            out_reg <= out_next;
        end
    end

endmodule

// ===== design/block_int8_requantize_tile_unit.sv =====
// Throughput: one item per cycle while result_stall is low; five pipeline
//   registers, each stage held by its own enable, so a stalled result only
//   backs up the full stages behind.
// Reset: rst_n asynchronous, active low; clears all stage valids and loads
//   k_size = 32, gain_bits = 0x42FE0000 (127.0). No clearing pass.
// ============================================================================
// block_int8_requantize_tile_unit
// Requantizes blockwise int8 weights (q * half scale * float factor, clamp,
// round half away) and forms the 32x32-tiled destination index.
// ============================================================================
module block_int8_requantize_tile_unit (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       item_valid,
    output logic                       item_stall,
    input  brq_pkg::brq_in_t           item,
    output logic                       result_valid,
    input  logic                       result_stall,
    output brq_pkg::brq_out_t          result,
    input  logic                       cfg_we,
    input  logic                       cfg_index,
    input  logic [brq_pkg::CFG_W-1:0]  cfg_data
);
    import brq_pkg::*;
    `include "block_int8_requantize_tile_unit_macros.svh"

    // Stages:
    //   1 decode   - half/single unpack, |q| x half significand, flags, index
    //   2 mul      - 19 x 24 exact product
    //   3 norm     - leading-zero count and shift
    //   4 round    - round to 24-bit significand, nearest even
    //   5 output   - clamp +-127, round half away, NaN -> -127

    logic [K_W-1:0]   k_size_reg;
    logic [CFG_W-1:0] gain_reg;
    brq_cfg_t         cfg;

    logic    v1, v2, v3, v4, v5;
    logic    en1, en2, en3, en4, en5;
    brq_s1_t s1;
    brq_s2_t s2;
    brq_s3_t s3;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            k_size_reg <= K_W'(32);
            gain_reg   <= 32'h42FE_0000;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_K_SIZE: k_size_reg <= cfg_data[K_W-1:0];
                CFG_SCALE:  gain_reg   <= cfg_data;
                default:    ;
            endcase
        end
    end

    assign cfg.k_size    = k_size_reg;
    assign cfg.gain_bits = gain_reg;

    // Stall chain: a stage moves when it is empty or the next one moves.
    assign en5 = !v5 || !result_stall;
    assign en4 = !v4 || en5;
    assign en3 = !v3 || en4;
    assign en2 = !v2 || en3;
    assign en1 = !v1 || en2;

    assign item_stall   = !en1;
    assign result_valid = v5;

    brq_decode u_decode (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en1),
        .in_valid  (item_valid),
        .in_data   (item),
        .cfg       (cfg),
        .valid_reg (v1),
        .data_reg  (s1)
    );

    brq_mul u_mul (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en2),
        .in_valid  (v1),
        .in_data   (s1),
        .valid_reg (v2),
        .data_reg  (s2)
    );

    brq_norm u_norm (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en3),
        .in_valid  (v2),
        .in_data   (s2),
        .valid_reg (v3),
        .data_reg  (s3)
    );

    brq_round u_round (
        .clk           (clk),
        .rst_n         (rst_n),
        .en_rnd        (en4),
        .en_out        (en5),
        .in_valid      (v3),
        .in_data       (s3),
        .rnd_valid_reg (v4),
        .out_valid_reg (v5),
        .out_reg       (result)
    );

    // Input backs up only when the whole pipe is full behind a stalled beat.
    `BRQ_ASSERT_IMP(a_stall_full, item_stall, result_valid && result_stall && v1 && v4,
                    "item stall without a full, stalled pipe")
    // An accepted beat lands in stage 1.
    `BRQ_ASSERT_NXT(a_accept_s1, item_valid && !item_stall, v1,
                    "accepted beat lost at stage 1")
    // A bubble behind a taken result empties the output register.
    `BRQ_ASSERT_NXT(a_bubble_out, result_valid && !result_stall && !v4, !result_valid,
                    "result repeated after a bubble")
    // Requantized value never reaches -128.
    `BRQ_ASSERT_IMP(a_value_range, result_valid, result.dest_value != -8'sd128,
                    "dest_value out of range")

endmodule

// ===== tb/block_int8_requantize_tile_unit_tb.sv =====
`timescale 1ns / 100ps
// ============================================================================
// block_int8_requantize_tile_unit_tb
// Drives weight elements through the requantize / tile-index unit and checks
// each result beat against a predictor built on exact real arithmetic, with
// single precision rounding applied explicitly. Runs directed corners, then
// random traffic under several idle / stall mixes and register settings.
// ============================================================================
module block_int8_requantize_tile_unit_tb;
    import brq_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_CYCLES = 12;   // pipeline is 5 deep, some margin

    logic                clk;
    logic                rst_n;
    logic                item_valid;
    logic                item_stall;
    brq_in_t             item;
    logic                result_valid;
    logic                result_stall;
    brq_out_t            result;
    logic                cfg_we;
    logic                cfg_index;
    logic [CFG_W-1:0]    cfg_data;

    // shadow copy of the unit's registers
    logic [K_W-1:0]      k_shadow;
    logic [31:0]         factor_shadow;

    brq_out_t            pending_results[$];
    int                  mismatch_count;
    int                  cycle_count;
    int                  send_idle_pct;
    int                  recv_stall_pct;

    block_int8_requantize_tile_unit dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always #10 clk = ~clk;

    // run limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------------
    // Round an exact double to the nearest single (ties to even). Values far
    // below single normal range or far above 127 come out right enough for
    // the clamp and round that follow, so only the mantissa is cut.
    function automatic real round_to_single(real x);
        logic [63:0] bits;
        logic [62:0] mag;
        logic [28:0] rest;
        begin
            if (x == 0.0)
                return 0.0;
            bits = $realtobits(x);
            mag  = bits[62:0];
            rest = mag[28:0];
            if (rest > 29'h1000_0000 || (rest == 29'h1000_0000 && mag[29]))
                mag = mag + 63'h2000_0000;
            mag[28:0] = '0;
            return $bitstoreal({bits[63], mag});
        end
    endfunction

    function automatic brq_out_t requant_element(brq_in_t it, logic [K_W-1:0] ksz,
                                                 logic [31:0] factor);
        brq_out_t   o;
        longint     k_eff;
        longint     idx;
        int         q;
        int         h_exp;
        int         f_exp;
        real        h_val;
        real        f_val;
        real        w;
        bit         h_nan, h_inf, f_nan, f_inf, h_zero, f_zero, neg;
        int         t;
        real        frac;
        begin
            k_eff = (ksz > MAX_K) ? MAX_K : ksz;
            idx = longint'(it.weight_row / 32) * (k_eff / 32) * 1024
                + longint'(it.weight_col / 32) * 1024
                + longint'(it.weight_row % 32) * 32
                + longint'(it.weight_col % 32);
            o.dest_index = idx[IDX_W-1:0];

            q      = int'(it.quant_value);
            h_exp  = int'(it.block_scale[14:10]);
            h_nan  = (h_exp == 31) && (it.block_scale[9:0] != 0);
            h_inf  = (h_exp == 31) && (it.block_scale[9:0] == 0);
            h_zero = it.block_scale[14:0] == 0;
            if (h_exp == 0)
                h_val = real'(it.block_scale[9:0]) * 2.0 ** (-24);
            else
                h_val = real'(1024 + it.block_scale[9:0]) * 2.0 ** (h_exp - 25);
            if (it.block_scale[15])
                h_val = -h_val;

            f_exp  = int'(factor[30:23]);
            f_nan  = (f_exp == 255) && (factor[22:0] != 0);
            f_inf  = (f_exp == 255) && (factor[22:0] == 0);
            f_zero = factor[30:0] == 0;
            if (f_exp == 0)
                f_val = real'(factor[22:0]) * 2.0 ** (-149);
            else
                f_val = real'(32'h0080_0000 + factor[22:0]) * 2.0 ** (f_exp - 150);
            if (factor[31])
                f_val = -f_val;

            neg = it.block_scale[15] ^ factor[31] ^ (q < 0);
            if (h_nan || f_nan)
                t = -127;
            else if (h_inf || f_inf)
            begin
                // infinity times zero is NaN
                if (q == 0 || (h_inf && f_zero) || (f_inf && h_zero))
                    t = -127;
                else
                    t = neg ? -127 : 127;
            end
            else
            begin
                // q * half * factor is exact in double
                w = round_to_single(real'(q) * h_val * f_val);
                if (w > 127.0)
                    w = 127.0;
                if (w < -127.0)
                    w = -127.0;
                t = $rtoi(w);
                frac = w - real'(t);
                if (frac >= 0.5)
                    t = t + 1;
                else if (frac <= -0.5)
                    t = t - 1;
            end
            o.dest_value = t[7:0];
            return o;
        end
    endfunction

    // ------------------------------------------------------------------------
    // Result checker and receiver stall
    // ------------------------------------------------------------------------
    task automatic report_mismatch(string field, longint got, longint want);
        begin
            mismatch_count = mismatch_count + 1;
            $display("MISMATCH @%0d %s: got %0d expected %0d", cycle_count, field, got, want);
        end
    endtask

    always @(negedge clk)
        if (rst_n)
            result_stall = ($urandom_range(99) < recv_stall_pct);

    always @(posedge clk)
    begin
        brq_out_t want;
        if (rst_n && result_valid && !result_stall)
        begin
            if (pending_results.size() == 0)
                report_mismatch("unexpected beat, index", result.dest_index, -1);
            else
            begin
                want = pending_results.pop_front();
                if (result.dest_index !== want.dest_index)
                    report_mismatch("dest_index", result.dest_index, want.dest_index);
                if (result.dest_value !== want.dest_value)
                    report_mismatch("dest_value", result.dest_value, want.dest_value);
            end
        end
    end

    // ------------------------------------------------------------------------
    // Shared driver tasks
    // ------------------------------------------------------------------------
    // One item beat; the expectation is queued at the accepting edge.
    task automatic send_element(brq_in_t it);
        begin
            while ($urandom_range(99) < send_idle_pct)
            begin
                item_valid = 1'b0;
                @(negedge clk);
            end
            item_valid = 1'b1;
            item = it;
            @(posedge clk);
            while (item_stall)
                @(posedge clk);
            pending_results.insert(pending_results.size(),
                                   requant_element(it, k_shadow, factor_shadow));
            @(negedge clk);
            item_valid = 1'b0;
        end
    endtask

    task automatic send_fields(int row, int col, int hs, int qv);
        brq_in_t it;
        begin
            it.weight_row  = row[11:0];
            it.weight_col  = col[11:0];
            it.block_scale = hs[15:0];
            it.quant_value = qv[7:0];
            send_element(it);
        end
    endtask

    task automatic wait_idle();
        begin
            while (pending_results.size() != 0)
                @(negedge clk);
            repeat (DRAIN_CYCLES) @(negedge clk);
        end
    endtask

    task automatic write_reg(logic idx, logic [31:0] value);
        begin
            wait_idle();
            cfg_we    = 1'b1;
            cfg_index = idx;
            cfg_data  = value;
            @(negedge clk);
            cfg_we    = 1'b0;
            if (idx == CFG_K_SIZE)
                k_shadow = value[K_W-1:0];
            else
                factor_shadow = value;
        end
    endtask

    // Random element: mostly plausible block scales so values land inside
    // the int8 range, the rest any half bit pattern.
    function automatic int rand_half();
        begin
            if ($urandom_range(3) == 0)
                return int'($urandom_range(16'hFFFF));
            return int'({$urandom_range(1), 5'($urandom_range(18, 4)),
                         10'($urandom_range(1023))});
        end
    endfunction

    function automatic logic [31:0] rand_factor();
        begin
            case ($urandom_range(5))
                0:       return $urandom;
                1:       return {1'b0, 8'($urandom_range(140, 110)), 23'($urandom)};
                default: return {1'b0, 8'($urandom_range(135, 127)), 23'($urandom)};
            endcase
        end
    endfunction

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------
    // Field extremes and value corners under reset settings.
    task automatic test_field_corners();
        begin
            send_fields(0, 0, 16'h3C00, 0);
            send_fields(4095, 4095, 16'h3C00, 127);
            send_fields(31, 32, 16'h3C00, -128);
            send_fields(33, 31, 16'hBC00, 1);
            send_fields(1, 2, 16'h3800, 1);      // exactly 63.5: ties away
            send_fields(1, 3, 16'h3800, -1);
            send_fields(5, 6, 16'h0001, 127);    // half subnormal
            send_fields(5, 7, 16'h83FF, -128);
            send_fields(7, 8, 16'h7C00, 3);      // infinite scale
            send_fields(7, 9, 16'hFC00, 3);
            send_fields(7, 10, 16'h7C00, 0);     // inf times zero
            send_fields(7, 11, 16'h7E01, 5);     // NaN scale
            send_fields(7, 12, 16'h7BFF, -128);  // huge, clamps
            send_fields(7, 13, 16'h8000, 100);   // negative zero
            send_fields(12'hAAA, 12'h555, 16'hAAAA, 8'h55);
            send_fields(12'h555, 12'hAAA, 16'h5555, 8'hAA);
        end
    endtask

    // Row-tile stride over k_size extremes, odd sizes and saturation.
    task automatic test_k_sizes();
        int sizes[6];
        begin
            sizes = '{4096, 8191, 0, 33, 4095, 32};
            foreach (sizes[i])
            begin
                write_reg(CFG_K_SIZE, 32'(sizes[i]));
                send_fields(4095, 4095, 16'h3C00, 9);
                send_fields(64, 4095, 16'h3C00, -9);
                send_fields(1000, 17, 16'h3C00, 1);
            end
        end
    endtask

    // Factor corners: zero, infinity, NaN, subnormal, max, one, negative.
    task automatic test_factors();
        logic [31:0] factors[8];
        begin
            factors = '{32'h0000_0000, 32'h7F80_0000, 32'hFFC0_0001, 32'h0000_0001,
                        32'h7F7F_FFFF, 32'h3F80_0000, 32'hBF00_0000, 32'hFFFF_FFFF};
            foreach (factors[i])
            begin
                write_reg(CFG_SCALE, factors[i]);
                send_fields(3, 4, 16'h3C00, 1);
                send_fields(3, 5, 16'h0000, 7);
                send_fields(3, 6, 16'h7C00, -7);
            end
            write_reg(CFG_SCALE, 32'h42FE_0000);
        end
    endtask

    // Random traffic over idle and stall mixes, with register changes between runs.
    task automatic test_random_traffic(int count);
        int phase_idle[4];
        int phase_stall[4];
        begin
            phase_idle  = '{0, 63, 0, 6};
            phase_stall = '{0, 0, 63, 6};
            for (int n = 0; n < count; n++)
            begin
                if (n % 100 == 0)
                begin
                    wait_idle();
                    send_idle_pct  = phase_idle[(n / 100) % 4];
                    recv_stall_pct = phase_stall[(n / 100) % 4];
                    if ($urandom_range(1))
                        write_reg(CFG_K_SIZE, $urandom_range(3) == 0 ?
                                  32'($urandom_range(8191)) : 32'($urandom_range(128, 1) * 32));
                    write_reg(CFG_SCALE, rand_factor());
                end
                send_fields($urandom_range(4095), $urandom_range(4095), rand_half(),
                            $urandom_range(255));
            end
        end
    endtask

    initial
    begin
        clk            = 1'b0;
        rst_n          = 1'b0;
        item_valid     = 1'b0;
        item           = '0;
        result_stall   = 1'b0;
        cfg_we         = 1'b0;
        cfg_index      = CFG_K_SIZE;
        cfg_data       = '0;
        k_shadow       = 13'd32;
        factor_shadow  = 32'h42FE_0000;
        mismatch_count = 0;
        cycle_count    = 0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        repeat (12) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_field_corners();
        send_idle_pct  = 30;
        recv_stall_pct = 30;
        test_k_sizes();
        test_factors();
        test_random_traffic(1700);
        wait_idle();

        if (mismatch_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

// ===== block_int8_requantize_tile_unit.f =====
+incdir+design
design/brq_pkg.sv
design/brq_decode.sv
design/brq_mul.sv
design/brq_norm.sv
design/brq_round.sv
design/block_int8_requantize_tile_unit.sv
tb/block_int8_requantize_tile_unit_tb.sv
